@@ rtl/kvt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvt_pkg
// Shared constants and types of the key-value get/set table.
// ----------------------------------------------------------------------------
package kvt_pkg;

  // table size and derived widths
  localparam int unsigned TABLE_ENTRIES = 64;
  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  // field widths
  localparam int unsigned OP_W  = 8;
  localparam int unsigned KEY_W = 32;
  localparam int unsigned VAL_W = 64;

  // request opcodes
  localparam logic [OP_W-1:0] OP_GET = 8'h00;
  localparam logic [OP_W-1:0] OP_SET = 8'h01;

  // get status codes
  localparam logic ST_HIT  = 1'b0;
  localparam logic ST_MISS = 1'b1;

  // command queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [QPTR_W-1:0] QLAST = QPTR_W'(QUEUE_DEPTH - 1);

  typedef enum logic {
    CMD_GET,
    CMD_SET
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e          op;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value_lo;
    logic [VAL_W-1:0] value_hi;
  } cmd_t;

endpackage

@@ rtl/kvt_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvt_if
// Request and response channels of the key-value get/set table.
// ----------------------------------------------------------------------------
interface kvt_req_if;
  logic                        valid;
  logic                        ready;
  logic [kvt_pkg::OP_W-1:0]    req_type;
  logic [kvt_pkg::KEY_W-1:0]   key;
  logic [kvt_pkg::VAL_W-1:0]   value_lo;
  logic [kvt_pkg::VAL_W-1:0]   value_hi;

  modport source (output valid, output req_type, output key, output value_lo,
                  output value_hi, input ready);
  modport sink   (input valid, input req_type, input key, input value_lo,
                  input value_hi, output ready);
endinterface

interface kvt_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        status;
  logic [kvt_pkg::VAL_W-1:0]   data_lo;
  logic [kvt_pkg::VAL_W-1:0]   data_hi;

  modport source (output valid, output status, output data_lo, output data_hi,
                  input ready);
  modport sink   (input valid, input status, input data_lo, input data_hi,
                  output ready);
endinterface

@@ rtl/kvt_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module kvt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/kvt_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvt_front
// Accepts requests, drops unknown opcodes and queues get/set commands.
// ----------------------------------------------------------------------------
module kvt_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  kvt_req_if.sink       req_i,
  output logic          cmd_valid_o,
  input  logic          cmd_ready_i,
  output kvt_pkg::cmd_t cmd_o
);

  kvt_pkg::cmd_t              q_mem_q [kvt_pkg::QUEUE_DEPTH];
  logic [kvt_pkg::QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [kvt_pkg::QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [kvt_pkg::QCNT_W-1:0] cnt_q, cnt_d;
  logic                       known;
  logic                       push;
  logic                       pop;
  kvt_pkg::cmd_t              cmd_new;

  // classify the opcode
  always_comb begin
    known  = 1'b0;
    cmd_new.op       = kvt_pkg::CMD_GET;
    cmd_new.key      = req_i.key;
    cmd_new.value_lo = req_i.value_lo;
    cmd_new.value_hi = req_i.value_hi;
    unique case (req_i.req_type)
      kvt_pkg::OP_GET: begin
        known      = 1'b1;
        cmd_new.op = kvt_pkg::CMD_GET;
      end
      kvt_pkg::OP_SET: begin
        known      = 1'b1;
        cmd_new.op = kvt_pkg::CMD_SET;
      end
      default: begin
        known = 1'b0;
      end
    endcase
  end

  assign req_i.ready = (cnt_q != kvt_pkg::QCNT_W'(kvt_pkg::QUEUE_DEPTH));
  assign push        = req_i.valid && req_i.ready && known;
  assign cmd_valid_o = (cnt_q != '0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = q_mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == kvt_pkg::QLAST) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == kvt_pkg::QLAST) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

@@ rtl/kvt_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvt_back
// Scans the key memory one entry per cycle and carries out gets and sets.
// ----------------------------------------------------------------------------
module kvt_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  output logic          cmd_ready_o,
  input  kvt_pkg::cmd_t cmd_i,
  kvt_rsp_if.source     rsp_o
);

  localparam int unsigned IDX_W = kvt_pkg::IDX_W;
  localparam int unsigned VAL_W = kvt_pkg::VAL_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_ACT  = 2'd2;
  localparam logic [1:0] S_RESP = 2'd3;

  logic [1:0]                       state_q, state_d;
  kvt_pkg::cmd_t                    cmd_q, cmd_d;
  logic [kvt_pkg::TABLE_ENTRIES-1:0] valid_q, valid_d;
  logic [IDX_W-1:0]                 rd_idx_q, rd_idx_d;
  logic                             rd_more_q, rd_more_d;
  logic [IDX_W-1:0]                 chk_idx_q, chk_idx_d;
  logic                             chk_vld_q, chk_vld_d;
  logic                             found_q, found_d;
  logic [IDX_W-1:0]                 slot_q, slot_d;
  logic                             free_fnd_q, free_fnd_d;
  logic [IDX_W-1:0]                 free_idx_q, free_idx_d;
  logic                             rsp_vld_q, rsp_vld_d;
  logic                             rsp_status_q, rsp_status_d;
  logic [VAL_W-1:0]                 rsp_lo_q, rsp_lo_d;
  logic [VAL_W-1:0]                 rsp_hi_q, rsp_hi_d;

  logic                             key_re;
  logic [kvt_pkg::KEY_W-1:0]        key_rdata;
  logic                             val_re;
  logic [2*VAL_W-1:0]               val_rdata;
  logic                             wr_en;
  logic [IDX_W-1:0]                 wr_idx;
  logic                             hit_now;
  logic                             free_now;
  logic                             end_now;

  kvt_ram #(
    .WIDTH (kvt_pkg::KEY_W),
    .DEPTH (kvt_pkg::TABLE_ENTRIES)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_idx),
    .wdata_i (cmd_q.key),
    .re_i    (key_re),
    .raddr_i (rd_idx_q),
    .rdata_o (key_rdata)
  );

  kvt_ram #(
    .WIDTH (2 * VAL_W),
    .DEPTH (kvt_pkg::TABLE_ENTRIES)
  ) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_idx),
    .wdata_i ({cmd_q.value_hi, cmd_q.value_lo}),
    .re_i    (val_re),
    .raddr_i (slot_q),
    .rdata_o (val_rdata)
  );

  // compare stage of the scan
  assign hit_now  = chk_vld_q && valid_q[chk_idx_q] && (key_rdata == cmd_q.key);
  assign free_now = chk_vld_q && !valid_q[chk_idx_q];
  assign end_now  = chk_vld_q && (hit_now || (chk_idx_q == kvt_pkg::LAST_IDX));

  assign key_re      = (state_q == S_SCAN) && rd_more_q;
  assign cmd_ready_o = (state_q == S_IDLE);

  assign rsp_o.valid   = rsp_vld_q;
  assign rsp_o.status  = rsp_status_q;
  assign rsp_o.data_lo = rsp_lo_q;
  assign rsp_o.data_hi = rsp_hi_q;

  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    valid_d      = valid_q;
    rd_idx_d     = rd_idx_q;
    rd_more_d    = rd_more_q;
    chk_idx_d    = rd_idx_q;
    chk_vld_d    = 1'b0;
    found_d      = found_q;
    slot_d       = slot_q;
    free_fnd_d   = free_fnd_q;
    free_idx_d   = free_idx_q;
    rsp_vld_d    = rsp_vld_q && !rsp_o.ready;
    rsp_status_d = rsp_status_q;
    rsp_lo_d     = rsp_lo_q;
    rsp_hi_d     = rsp_hi_q;
    val_re       = 1'b0;
    wr_en        = 1'b0;
    wr_idx       = found_q ? slot_q : free_idx_q;

    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_d      = cmd_i;
          rd_idx_d   = '0;
          rd_more_d  = 1'b1;
          found_d    = 1'b0;
          free_fnd_d = 1'b0;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        if (key_re) begin
          if (rd_idx_q == kvt_pkg::LAST_IDX) begin
            rd_more_d = 1'b0;
          end else begin
            rd_idx_d = rd_idx_q + 1'b1;
          end
        end
        chk_vld_d = key_re && !end_now;
        if (free_now && !free_fnd_q) begin
          free_fnd_d = 1'b1;
          free_idx_d = chk_idx_q;
        end
        if (hit_now) begin
          found_d = 1'b1;
          slot_d  = chk_idx_q;
        end
        if (end_now) begin
          rd_more_d = 1'b0;
          state_d   = S_ACT;
        end
      end
      S_ACT: begin
        if (cmd_q.op == kvt_pkg::CMD_SET) begin
          // overwrite the match, else fill the first free entry, else drop
          wr_en = found_q || free_fnd_q;
          if (wr_en) begin
            valid_d[wr_idx] = 1'b1;
          end
          state_d = S_IDLE;
        end else begin
          val_re  = found_q;
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (!rsp_vld_q || rsp_o.ready) begin
          rsp_vld_d    = 1'b1;
          rsp_status_d = found_q ? kvt_pkg::ST_HIT : kvt_pkg::ST_MISS;
          rsp_lo_d     = found_q ? val_rdata[VAL_W-1:0] : '0;
          rsp_hi_d     = found_q ? val_rdata[2*VAL_W-1:VAL_W] : '0;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      valid_q    <= '0;
      rd_more_q  <= 1'b0;
      chk_vld_q  <= 1'b0;
      found_q    <= 1'b0;
      free_fnd_q <= 1'b0;
      rsp_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      valid_q    <= valid_d;
      rd_more_q  <= rd_more_d;
      chk_vld_q  <= chk_vld_d;
      found_q    <= found_d;
      free_fnd_q <= free_fnd_d;
      rsp_vld_q  <= rsp_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    rd_idx_q     <= rd_idx_d;
    chk_idx_q    <= chk_idx_d;
    slot_q       <= slot_d;
    free_idx_q   <= free_idx_d;
    rsp_status_q <= rsp_status_d;
    rsp_lo_q     <= rsp_lo_d;
    rsp_hi_q     <= rsp_hi_d;
  end

endmodule

@@ rtl/key_value_get_set_table_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_value_get_set_table_top
// Associative get/set store with 32-bit keys and 128-bit values.
// ----------------------------------------------------------------------------
// A get or set request goes through a two-entry command queue to a back end
// that reads the key memory one entry per cycle. A request is handled in
// steps: the back end takes the command, reads each entry and compares its
// registered read data, then updates or fetches the value, and for a get
// loads the response register. A key found early ends the scan early.
// Requests with an unknown opcode are accepted when the queue has room and
// give nothing. A get always gives one response; a set gives none and is
// dropped when no entry matches and none is free. Valid bits clear at reset,
// so the block takes requests right after reset.
module key_value_get_set_table_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  kvt_req_if.sink   req_i,
  kvt_rsp_if.source rsp_o
);

  logic          cmd_valid;
  logic          cmd_ready;
  kvt_pkg::cmd_t cmd;

  kvt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  kvt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .rsp_o       (rsp_o)
  );

endmodule
